// ----- hdl/bdop_pkg.sv -----
// Package with shared types and constants of the BOOTP/DHCP option parser.
`default_nettype none

package bdop_pkg;

    localparam logic [2:0] KIND_HDR_WORD  = 3'd0;
    localparam logic [2:0] KIND_HDR_BYTE  = 3'd1;
    localparam logic [2:0] KIND_OPT_BYTE  = 3'd2;
    localparam logic [2:0] KIND_OPT_EMPTY = 3'd3;
    localparam logic [2:0] KIND_DONE      = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_SNAME = 3'd2;
    localparam logic [2:0] ST_BAD_FILE  = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    localparam logic [3:0] FID_XID    = 4'd4;
    localparam logic [3:0] FID_SECS   = 4'd5;
    localparam logic [3:0] FID_CIADDR = 4'd6;
    localparam logic [3:0] FID_YIADDR = 4'd7;
    localparam logic [3:0] FID_SIADDR = 4'd8;
    localparam logic [3:0] FID_GIADDR = 4'd9;
    localparam logic [3:0] FID_CHADDR = 4'd10;
    localparam logic [3:0] FID_SNAME  = 4'd11;
    localparam logic [3:0] FID_FILE   = 4'd12;
    localparam logic [3:0] FID_COOKIE = 4'd13;

    localparam logic [7:0] OPT_PAD    = 8'd0;
    localparam logic [7:0] OPT_VENDOR = 8'd43;
    localparam logic [7:0] OPT_END    = 8'd255;

    localparam logic [10:0] MIN_LEN_RESET = 11'd300;
    localparam int          HEADER_BYTES  = 240;
    localparam int          RESULT_BITS   = 72;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_CODE   = 6'b000010,
        PH_LEN    = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_VENDOR = 6'b010000,
        PH_END    = 6'b100000
    } t_phase;

    typedef enum logic [3:0] {
        SUB_INACTIVE = 4'b0001,
        SUB_CODE     = 4'b0010,
        SUB_LEN      = 4'b0100,
        SUB_DATA     = 4'b1000
    } t_sub_phase;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  field_id;
        logic [31:0] value;
        logic [7:0]  opt_code;
        logic [7:0]  sub_code;
        logic [7:0]  opt_len;
        logic [7:0]  byte_index;
        logic [2:0]  status;
        logic        last;
    } t_result;

    typedef struct packed {
        logic    valid_a;
        t_result res_a;
        logic    valid_b;
        t_result res_b;
    } t_push;

endpackage

`default_nettype wire

// ----- hdl/bdop_parser.sv -----
// Packet state and per-byte result generation of the BOOTP/DHCP option parser.
`default_nettype none

module bdop_parser #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire  [7:0]       i_byte,
    input  wire              i_last,
    input  wire  [10:0]      i_min_len,
    output bdop_pkg::t_push  o_push
);

    localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CW = (PW > 11) ? PW : 11;

    logic [PW-1:0]          r_pos,       n_pos;
    bdop_pkg::t_phase       r_phase,     n_phase;
    logic [31:0]            r_acc,       n_acc;
    logic [7:0]             r_code,      n_code;
    logic [7:0]             r_len,       n_len;
    logic [7:0]             r_rem,       n_rem;
    logic [7:0]             r_vrem,      n_vrem;
    bdop_pkg::t_sub_phase   r_sub_phase, n_sub_phase;
    logic [7:0]             r_sub_code,  n_sub_code;
    logic [2:0]             r_err,       n_err;
    logic                   r_skip,      n_skip;

    logic [7:0]             p8;
    logic [7:0]             rem_dec;
    logic [CW-1:0]          pos_x;
    logic [CW-1:0]          min_x;
    bdop_pkg::t_result      res_a;
    bdop_pkg::t_result      res_b;
    logic                   valid_a;
    logic                   valid_b;

    always_comb begin
        n_pos       = r_pos;
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_code      = r_code;
        n_len       = r_len;
        n_rem       = r_rem;
        n_vrem      = r_vrem;
        n_sub_phase = r_sub_phase;
        n_sub_code  = r_sub_code;
        n_err       = r_err;
        n_skip      = r_skip;
        res_a       = '0;
        res_b       = '0;
        valid_a     = 1'b0;
        valid_b     = 1'b0;
        p8          = r_pos[7:0];
        rem_dec     = r_rem - 8'd1;
        pos_x       = '0;
        min_x       = CW'(i_min_len);

        if (i_valid) begin
            if (r_pos < PW'(MAX_PACKET_BYTES)) begin
                if (r_phase == bdop_pkg::PH_HEADER) begin
                    n_acc = {r_acc[23:0], i_byte};
                    case (p8) inside
                        [8'd0:8'd3]: begin
                            valid_a        = 1'b1;
                            res_a.kind     = bdop_pkg::KIND_HDR_WORD;
                            res_a.field_id = p8[3:0];
                            res_a.value    = {24'd0, i_byte};
                        end
                        8'd7: begin
                            valid_a        = 1'b1;
                            res_a.kind     = bdop_pkg::KIND_HDR_WORD;
                            res_a.field_id = bdop_pkg::FID_XID;
                            res_a.value    = n_acc;
                        end
                        8'd9: begin
                            valid_a        = 1'b1;
                            res_a.kind     = bdop_pkg::KIND_HDR_WORD;
                            res_a.field_id = bdop_pkg::FID_SECS;
                            res_a.value    = {16'd0, n_acc[15:0]};
                        end
                        8'd15, 8'd19, 8'd23, 8'd27: begin
                            valid_a     = 1'b1;
                            res_a.kind  = bdop_pkg::KIND_HDR_WORD;
                            res_a.value = n_acc;
                            case (p8)
                                8'd15:   res_a.field_id = bdop_pkg::FID_CIADDR;
                                8'd19:   res_a.field_id = bdop_pkg::FID_YIADDR;
                                8'd23:   res_a.field_id = bdop_pkg::FID_SIADDR;
                                default: res_a.field_id = bdop_pkg::FID_GIADDR;
                            endcase
                        end
                        [8'd28:8'd43]: begin
                            valid_a          = 1'b1;
                            res_a.kind       = bdop_pkg::KIND_HDR_BYTE;
                            res_a.field_id   = bdop_pkg::FID_CHADDR;
                            res_a.value      = {24'd0, i_byte};
                            res_a.byte_index = p8 - 8'd28;
                        end
                        [8'd44:8'd107]: begin
                            valid_a          = 1'b1;
                            res_a.kind       = bdop_pkg::KIND_HDR_BYTE;
                            res_a.field_id   = bdop_pkg::FID_SNAME;
                            res_a.value      = {24'd0, i_byte};
                            res_a.byte_index = p8 - 8'd44;
                        end
                        [8'd108:8'd235]: begin
                            valid_a          = 1'b1;
                            res_a.kind       = bdop_pkg::KIND_HDR_BYTE;
                            res_a.field_id   = bdop_pkg::FID_FILE;
                            res_a.value      = {24'd0, i_byte};
                            res_a.byte_index = p8 - 8'd108;
                        end
                        8'd239: begin
                            valid_a        = 1'b1;
                            res_a.kind     = bdop_pkg::KIND_HDR_WORD;
                            res_a.field_id = bdop_pkg::FID_COOKIE;
                            res_a.value    = n_acc;
                        end
                        default: begin
                        end
                    endcase
                    if (p8 == 8'd107 && i_byte != 8'd0 && n_err == bdop_pkg::ST_OK) begin
                        n_err = bdop_pkg::ST_BAD_SNAME;
                    end
                    if (p8 == 8'd235 && i_byte != 8'd0 && n_err == bdop_pkg::ST_OK) begin
                        n_err = bdop_pkg::ST_BAD_FILE;
                    end
                    if (p8 == 8'd236 && i_byte == 8'hff) begin
                        n_skip = 1'b1;
                    end
                    if (p8 == 8'd239) begin
                        n_phase = r_skip ? bdop_pkg::PH_END : bdop_pkg::PH_CODE;
                    end
                end else begin
                    case (r_phase)
                        bdop_pkg::PH_CODE: begin
                            if (i_byte == bdop_pkg::OPT_END) begin
                                n_phase = bdop_pkg::PH_END;
                            end else if (i_byte != bdop_pkg::OPT_PAD) begin
                                n_code     = i_byte;
                                n_sub_code = 8'd0;
                                n_phase    = bdop_pkg::PH_LEN;
                            end
                        end
                        bdop_pkg::PH_LEN: begin
                            n_len = i_byte;
                            n_rem = i_byte;
                            if (r_code == bdop_pkg::OPT_VENDOR) begin
                                n_vrem = i_byte;
                                if (i_byte == 8'd0) begin
                                    n_phase = bdop_pkg::PH_CODE;
                                end else begin
                                    n_sub_phase = bdop_pkg::SUB_CODE;
                                    n_phase     = bdop_pkg::PH_VENDOR;
                                end
                            end else if (i_byte == 8'd0) begin
                                valid_a        = 1'b1;
                                res_a.kind     = bdop_pkg::KIND_OPT_EMPTY;
                                res_a.opt_code = r_code;
                                n_phase        = bdop_pkg::PH_CODE;
                            end else begin
                                n_phase = bdop_pkg::PH_DATA;
                            end
                        end
                        bdop_pkg::PH_DATA: begin
                            valid_a          = 1'b1;
                            res_a.kind       = bdop_pkg::KIND_OPT_BYTE;
                            res_a.value      = {24'd0, i_byte};
                            res_a.opt_code   = r_code;
                            res_a.opt_len    = r_len;
                            res_a.byte_index = r_len - r_rem;
                            n_rem            = rem_dec;
                            if (rem_dec == 8'd0) begin
                                n_phase = bdop_pkg::PH_CODE;
                            end
                        end
                        bdop_pkg::PH_VENDOR: begin
                            case (r_sub_phase)
                                bdop_pkg::SUB_CODE: begin
                                    if (i_byte == bdop_pkg::OPT_END ||
                                        i_byte == bdop_pkg::OPT_VENDOR) begin
                                        n_sub_phase = bdop_pkg::SUB_INACTIVE;
                                    end else if (i_byte != bdop_pkg::OPT_PAD) begin
                                        n_sub_code  = i_byte;
                                        n_sub_phase = bdop_pkg::SUB_LEN;
                                    end
                                end
                                bdop_pkg::SUB_LEN: begin
                                    n_len = i_byte;
                                    n_rem = i_byte;
                                    if (i_byte == 8'd0) begin
                                        valid_a        = 1'b1;
                                        res_a.kind     = bdop_pkg::KIND_OPT_EMPTY;
                                        res_a.opt_code = bdop_pkg::OPT_VENDOR;
                                        res_a.sub_code = r_sub_code;
                                        n_sub_phase    = bdop_pkg::SUB_CODE;
                                    end else begin
                                        n_sub_phase = bdop_pkg::SUB_DATA;
                                    end
                                end
                                bdop_pkg::SUB_DATA: begin
                                    valid_a          = 1'b1;
                                    res_a.kind       = bdop_pkg::KIND_OPT_BYTE;
                                    res_a.value      = {24'd0, i_byte};
                                    res_a.opt_code   = bdop_pkg::OPT_VENDOR;
                                    res_a.sub_code   = r_sub_code;
                                    res_a.opt_len    = r_len;
                                    res_a.byte_index = r_len - r_rem;
                                    n_rem            = rem_dec;
                                    if (rem_dec == 8'd0) begin
                                        n_sub_phase = bdop_pkg::SUB_CODE;
                                    end
                                end
                                default: begin
                                end
                            endcase
                            n_vrem = r_vrem - 8'd1;
                            if (n_vrem == 8'd0) begin
                                if ((n_sub_phase == bdop_pkg::SUB_LEN ||
                                     n_sub_phase == bdop_pkg::SUB_DATA) &&
                                    n_err == bdop_pkg::ST_OK) begin
                                    n_err = bdop_pkg::ST_TRUNC;
                                end
                                n_sub_phase = bdop_pkg::SUB_INACTIVE;
                                n_phase     = bdop_pkg::PH_CODE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                n_pos = r_pos + PW'(1);
            end

            if (i_last) begin
                if ((n_phase == bdop_pkg::PH_LEN || n_phase == bdop_pkg::PH_DATA ||
                     n_phase == bdop_pkg::PH_VENDOR) && n_err == bdop_pkg::ST_OK) begin
                    n_err = bdop_pkg::ST_TRUNC;
                end
                pos_x        = CW'(n_pos);
                valid_b      = 1'b1;
                res_b.kind   = bdop_pkg::KIND_DONE;
                res_b.last   = 1'b1;
                if (pos_x < CW'(bdop_pkg::HEADER_BYTES) || pos_x < min_x) begin
                    res_b.status = bdop_pkg::ST_SHORT;
                end else begin
                    res_b.status = n_err;
                end
                n_pos       = '0;
                n_phase     = bdop_pkg::PH_HEADER;
                n_acc       = '0;
                n_code      = '0;
                n_len       = '0;
                n_rem       = '0;
                n_vrem      = '0;
                n_sub_phase = bdop_pkg::SUB_INACTIVE;
                n_sub_code  = '0;
                n_err       = bdop_pkg::ST_OK;
                n_skip      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_phase     <= bdop_pkg::PH_HEADER;
            r_acc       <= '0;
            r_code      <= '0;
            r_len       <= '0;
            r_rem       <= '0;
            r_vrem      <= '0;
            r_sub_phase <= bdop_pkg::SUB_INACTIVE;
            r_sub_code  <= '0;
            r_err       <= bdop_pkg::ST_OK;
            r_skip      <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_code      <= n_code;
            r_len       <= n_len;
            r_rem       <= n_rem;
            r_vrem      <= n_vrem;
            r_sub_phase <= n_sub_phase;
            r_sub_code  <= n_sub_code;
            r_err       <= n_err;
            r_skip      <= n_skip;
        end
    end

    assign o_push.valid_a = valid_a;
    assign o_push.res_a   = res_a;
    assign o_push.valid_b = valid_b;
    assign o_push.res_b   = res_b;

endmodule

`default_nettype wire

// ----- hdl/bdop_out_fifo.sv -----
// Result queue taking up to two results per cycle and giving out one.
`default_nettype none

module bdop_out_fifo (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire bdop_pkg::t_push     i_push,
    input  wire                      i_pop,
    output logic                     o_valid,
    output bdop_pkg::t_result        o_data,
    output logic [3:0]               o_count
);

    bdop_pkg::t_result r_mem [8];
    logic [2:0]        r_wr_ptr, n_wr_ptr;
    logic [2:0]        r_rd_ptr, n_rd_ptr;
    logic [3:0]        r_count,  n_count;
    logic [2:0]        wr_ptr_b;
    logic              pop_ok;

    always_comb begin
        pop_ok   = i_pop && (r_count != 4'd0);
        wr_ptr_b = i_push.valid_a ? r_wr_ptr + 3'd1 : r_wr_ptr;
        n_wr_ptr = r_wr_ptr + {2'd0, i_push.valid_a} + {2'd0, i_push.valid_b};
        n_rd_ptr = r_rd_ptr + {2'd0, pop_ok};
        n_count  = r_count + {3'd0, i_push.valid_a} + {3'd0, i_push.valid_b}
                   - {3'd0, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid_a) begin
            r_mem[r_wr_ptr] <= i_push.res_a;
        end
        if (i_push.valid_b) begin
            r_mem[wr_ptr_b] <= i_push.res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_valid = (r_count != 4'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- hdl/bootp_dhcp_option_parser.sv -----
// Top level of the BOOTP/DHCP packet and option parser.
// Each result passes through the input register and then the result queue before it leaves.
// Throughput: one byte per cycle; the packet-done result takes one extra output slot,
// absorbed by an eight-entry result queue; input stalls while it holds more than four.
// Reset is synchronous and active low: it clears all packet state and sets the
// minimum packet length to 300.
`default_nettype none

module bootp_dhcp_option_parser #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [10:0] i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // data_byte
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // field_id, value, opt_code, sub_code, opt_len, byte_index, status, zero pad
    output logic [bdop_pkg::RESULT_BITS-1:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic [10:0]       r_min_len;
    logic              in_accept;
    logic [3:0]        fifo_count;
    bdop_pkg::t_push   push;
    bdop_pkg::t_result out_res;

    assign s_axis_tready = (fifo_count <= 4'd4);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_min_len  <= bdop_pkg::MIN_LEN_RESET;
        end else begin
            r_in_valid <= in_accept;
            if (i_cfg_we) begin
                r_min_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    bdop_parser #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_in_valid),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_min_len (r_min_len),
        .o_push    (push)
    );

    bdop_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (out_res),
        .o_count (fifo_count)
    );

    assign m_axis_tdata = {1'b0, out_res.status, out_res.byte_index, out_res.opt_len,
                           out_res.sub_code, out_res.opt_code, out_res.value,
                           out_res.field_id};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the BOOTP/DHCP packet and option parser.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_BYTES      = 2048;
    localparam int SETTLE_CYCLES  = 6;
    localparam int END_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF       = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    bootp_dhcp_option_parser #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Parser state mirrored by the prediction.
    logic [10:0]          cfg_min_len;
    int unsigned          ps_pos;
    bdop_pkg::t_phase     ps_phase;
    logic [31:0]          ps_acc;
    logic [7:0]           ps_code;
    logic [7:0]           ps_len;
    logic [7:0]           ps_left;
    logic [7:0]           ps_vleft;
    logic [7:0]           ps_sub;
    bdop_pkg::t_sub_phase ps_sphase;
    logic [2:0]           ps_err;
    logic                 ps_skip;

    bdop_pkg::t_result    pending_results[$];
    logic [7:0]           pkt_bytes[$];
    logic [7:0]           sub_area[$];

    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          hold_cycles = 0;
    int          quiet_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned packets_sent = 0;
    int unsigned results_seen = 0;

    function automatic void clear_parser();
        ps_pos    = 0;
        ps_phase  = bdop_pkg::PH_HEADER;
        ps_acc    = '0;
        ps_code   = '0;
        ps_len    = '0;
        ps_left   = '0;
        ps_vleft  = '0;
        ps_sub    = '0;
        ps_sphase = bdop_pkg::SUB_INACTIVE;
        ps_err    = bdop_pkg::ST_OK;
        ps_skip   = 1'b0;
    endfunction

    function automatic void emit(logic [2:0] kind, logic [3:0] fid, logic [31:0] value,
                                 logic [7:0] code, logic [7:0] sub, logic [7:0] len,
                                 logic [7:0] idx, logic [2:0] status, logic last);
        bdop_pkg::t_result r;
        r.kind       = kind;
        r.field_id   = fid;
        r.value      = value;
        r.opt_code   = code;
        r.sub_code   = sub;
        r.opt_len    = len;
        r.byte_index = idx;
        r.status     = status;
        r.last       = last;
        pending_results.push_back(r);
    endfunction

    function automatic void raise_status(logic [2:0] e);
        if (ps_err == bdop_pkg::ST_OK) begin
            ps_err = e;
        end
    endfunction

    function automatic void parse_header(int unsigned p, logic [7:0] b);
        ps_acc = {ps_acc[23:0], b};
        if (p < 4) begin
            emit(bdop_pkg::KIND_HDR_WORD, 4'(p), {24'd0, b}, 0, 0, 0, 0, bdop_pkg::ST_OK, 0);
        end else if (p == 7) begin
            emit(bdop_pkg::KIND_HDR_WORD, bdop_pkg::FID_XID, ps_acc, 0, 0, 0, 0,
                 bdop_pkg::ST_OK, 0);
        end else if (p == 9) begin
            emit(bdop_pkg::KIND_HDR_WORD, bdop_pkg::FID_SECS, {16'd0, ps_acc[15:0]},
                 0, 0, 0, 0, bdop_pkg::ST_OK, 0);
        end else if (p >= 15 && p <= 27 && ((p - 15) % 4) == 0) begin
            emit(bdop_pkg::KIND_HDR_WORD, bdop_pkg::FID_CIADDR + 4'((p - 15) / 4), ps_acc,
                 0, 0, 0, 0, bdop_pkg::ST_OK, 0);
        end else if (p >= 28 && p < 44) begin
            emit(bdop_pkg::KIND_HDR_BYTE, bdop_pkg::FID_CHADDR, {24'd0, b}, 0, 0, 0,
                 8'(p - 28), bdop_pkg::ST_OK, 0);
        end else if (p >= 44 && p < 108) begin
            emit(bdop_pkg::KIND_HDR_BYTE, bdop_pkg::FID_SNAME, {24'd0, b}, 0, 0, 0,
                 8'(p - 44), bdop_pkg::ST_OK, 0);
        end else if (p >= 108 && p < 236) begin
            emit(bdop_pkg::KIND_HDR_BYTE, bdop_pkg::FID_FILE, {24'd0, b}, 0, 0, 0,
                 8'(p - 108), bdop_pkg::ST_OK, 0);
        end else if (p == 239) begin
            emit(bdop_pkg::KIND_HDR_WORD, bdop_pkg::FID_COOKIE, ps_acc, 0, 0, 0, 0,
                 bdop_pkg::ST_OK, 0);
        end
        if (p == 107 && b != 8'd0) begin
            raise_status(bdop_pkg::ST_BAD_SNAME);
        end
        if (p == 235 && b != 8'd0) begin
            raise_status(bdop_pkg::ST_BAD_FILE);
        end
        if (p == 236 && b == 8'hff) begin
            ps_skip = 1'b1;
        end
        if (p == 239) begin
            ps_phase = ps_skip ? bdop_pkg::PH_END : bdop_pkg::PH_CODE;
        end
    endfunction

    function automatic void parse_vendor(logic [7:0] b);
        case (ps_sphase)
            bdop_pkg::SUB_CODE: begin
                if (b == bdop_pkg::OPT_END || b == bdop_pkg::OPT_VENDOR) begin
                    ps_sphase = bdop_pkg::SUB_INACTIVE;
                end else if (b != bdop_pkg::OPT_PAD) begin
                    ps_sub    = b;
                    ps_sphase = bdop_pkg::SUB_LEN;
                end
            end
            bdop_pkg::SUB_LEN: begin
                ps_len  = b;
                ps_left = b;
                if (b == 8'd0) begin
                    emit(bdop_pkg::KIND_OPT_EMPTY, 0, 0, bdop_pkg::OPT_VENDOR, ps_sub, 0, 0,
                         bdop_pkg::ST_OK, 0);
                    ps_sphase = bdop_pkg::SUB_CODE;
                end else begin
                    ps_sphase = bdop_pkg::SUB_DATA;
                end
            end
            bdop_pkg::SUB_DATA: begin
                emit(bdop_pkg::KIND_OPT_BYTE, 0, {24'd0, b}, bdop_pkg::OPT_VENDOR, ps_sub,
                     ps_len, ps_len - ps_left, bdop_pkg::ST_OK, 0);
                ps_left = ps_left - 8'd1;
                if (ps_left == 8'd0) begin
                    ps_sphase = bdop_pkg::SUB_CODE;
                end
            end
            default: ;
        endcase
        ps_vleft = ps_vleft - 8'd1;
        if (ps_vleft == 8'd0) begin
            if (ps_sphase == bdop_pkg::SUB_LEN || ps_sphase == bdop_pkg::SUB_DATA) begin
                raise_status(bdop_pkg::ST_TRUNC);
            end
            ps_sphase = bdop_pkg::SUB_INACTIVE;
            ps_phase  = bdop_pkg::PH_CODE;
        end
    endfunction

    function automatic void parse_option(logic [7:0] b);
        case (ps_phase)
            bdop_pkg::PH_CODE: begin
                if (b == bdop_pkg::OPT_END) begin
                    ps_phase = bdop_pkg::PH_END;
                end else if (b != bdop_pkg::OPT_PAD) begin
                    ps_code  = b;
                    ps_sub   = 8'd0;
                    ps_phase = bdop_pkg::PH_LEN;
                end
            end
            bdop_pkg::PH_LEN: begin
                ps_len  = b;
                ps_left = b;
                if (ps_code == bdop_pkg::OPT_VENDOR) begin
                    ps_vleft = b;
                    if (b == 8'd0) begin
                        ps_phase = bdop_pkg::PH_CODE;
                    end else begin
                        ps_sphase = bdop_pkg::SUB_CODE;
                        ps_phase  = bdop_pkg::PH_VENDOR;
                    end
                end else if (b == 8'd0) begin
                    emit(bdop_pkg::KIND_OPT_EMPTY, 0, 0, ps_code, 0, 0, 0, bdop_pkg::ST_OK, 0);
                    ps_phase = bdop_pkg::PH_CODE;
                end else begin
                    ps_phase = bdop_pkg::PH_DATA;
                end
            end
            bdop_pkg::PH_DATA: begin
                emit(bdop_pkg::KIND_OPT_BYTE, 0, {24'd0, b}, ps_code, 0, ps_len,
                     ps_len - ps_left, bdop_pkg::ST_OK, 0);
                ps_left = ps_left - 8'd1;
                if (ps_left == 8'd0) begin
                    ps_phase = bdop_pkg::PH_CODE;
                end
            end
            bdop_pkg::PH_VENDOR: begin
                parse_vendor(b);
            end
            default: ;
        endcase
    endfunction

    function automatic void parser_step(logic [7:0] b, logic lastb);
        logic [2:0] st;
        if (ps_pos < MAX_BYTES) begin
            if (ps_phase == bdop_pkg::PH_HEADER) begin
                parse_header(ps_pos, b);
            end else begin
                parse_option(b);
            end
            ps_pos++;
        end
        if (lastb) begin
            if (ps_phase == bdop_pkg::PH_LEN || ps_phase == bdop_pkg::PH_DATA ||
                ps_phase == bdop_pkg::PH_VENDOR) begin
                raise_status(bdop_pkg::ST_TRUNC);
            end
            st = (ps_pos < bdop_pkg::HEADER_BYTES || ps_pos < cfg_min_len) ?
                 bdop_pkg::ST_SHORT : ps_err;
            emit(bdop_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0, st, 1);
            clear_parser();
        end
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic void begin_packet();
        pkt_bytes.delete();
        repeat (bdop_pkg::HEADER_BYTES) pkt_bytes.push_back(rand_byte());
        pkt_bytes[107] = 8'd0;
        pkt_bytes[235] = 8'd0;
        pkt_bytes[236] = 8'h63;
        pkt_bytes[237] = 8'h82;
        pkt_bytes[238] = 8'h53;
        pkt_bytes[239] = 8'h63;
    endfunction

    function automatic void add_option(logic [7:0] code, int len);
        pkt_bytes.push_back(code);
        pkt_bytes.push_back(8'(len));
        repeat (len) pkt_bytes.push_back(rand_byte());
    endfunction

    function automatic void add_sub(logic [7:0] code, int len);
        sub_area.push_back(code);
        sub_area.push_back(8'(len));
        repeat (len) sub_area.push_back(rand_byte());
    endfunction

    function automatic void add_vendor_area();
        pkt_bytes.push_back(bdop_pkg::OPT_VENDOR);
        pkt_bytes.push_back(8'(sub_area.size()));
        foreach (sub_area[i]) pkt_bytes.push_back(sub_area[i]);
        sub_area.delete();
    endfunction

    function automatic void pad_to(int n);
        while (pkt_bytes.size() < n) pkt_bytes.push_back(bdop_pkg::OPT_PAD);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lastb);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lastb;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        parser_step(b, lastb);
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_bytes.size(); i++) begin
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        end
        packets_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_len(input logic [10:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_min_len = v;
    endtask

    task automatic test_min_length_reset();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        pkt_bytes.delete();
        pkt_bytes.push_back(rand_byte());
        send_packet();
        begin_packet();
        add_option(8'd53, 1);
        add_option(8'd12, 0);
        pad_to(300);
        send_packet();
    endtask

    task automatic test_header_extremes();
        write_min_len(11'd240);
        src_idle_pct = 75;
        pkt_bytes.delete();
        repeat (bdop_pkg::HEADER_BYTES) pkt_bytes.push_back(8'hff);
        send_packet();
        src_idle_pct = 0;
    endtask

    task automatic test_option_records();
        sink_stall_pct = 75;
        begin_packet();
        pkt_bytes.push_back(bdop_pkg::OPT_PAD);
        add_option(8'd1, 4);
        add_option(8'd12, 0);
        add_option(bdop_pkg::OPT_VENDOR, 0);
        sub_area.push_back(bdop_pkg::OPT_PAD);
        add_sub(8'd1, 2);
        add_sub(8'd5, 0);
        add_sub(8'd254, 1);
        sub_area.push_back(bdop_pkg::OPT_END);
        sub_area.push_back(rand_byte());
        sub_area.push_back(rand_byte());
        add_vendor_area();
        add_sub(8'd3, 1);
        sub_area.push_back(bdop_pkg::OPT_VENDOR);
        sub_area.push_back(rand_byte());
        add_vendor_area();
        // A sub-option that declares more data than its enclosing area holds.
        sub_area.push_back(8'd7);
        sub_area.push_back(8'd5);
        sub_area.push_back(rand_byte());
        sub_area.push_back(rand_byte());
        add_vendor_area();
        add_option(8'd254, 3);
        pkt_bytes.push_back(bdop_pkg::OPT_END);
        repeat (2) pkt_bytes.push_back(rand_byte());
        send_packet();
        sink_stall_pct = 0;
    endtask

    task automatic test_truncated_options();
        src_idle_pct   = 11;
        sink_stall_pct = 11;
        begin_packet();
        pkt_bytes[107] = 8'h80;
        pkt_bytes[235] = 8'h01;
        add_option(8'd5, 10);
        repeat (4) void'(pkt_bytes.pop_back());
        send_packet();
        begin_packet();
        pkt_bytes[107] = 8'h01;
        repeat (bdop_pkg::HEADER_BYTES - 108) void'(pkt_bytes.pop_back());
        send_packet();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_cycles = HOLD_OFF;
        pkt_bytes.delete();
        repeat (60) pkt_bytes.push_back(rand_byte());
        send_packet();
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        bdop_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $error("result transaction arrived with no prediction pending");
            end else begin
                want = pending_results.pop_front();
                compare_field("kind", want.kind, m_axis_tuser);
                compare_field("field_id", want.field_id, m_axis_tdata[3:0]);
                compare_field("value", want.value, m_axis_tdata[35:4]);
                compare_field("opt_code", want.opt_code, m_axis_tdata[43:36]);
                compare_field("sub_code", want.sub_code, m_axis_tdata[51:44]);
                compare_field("opt_len", want.opt_len, m_axis_tdata[59:52]);
                compare_field("byte_index", want.byte_index, m_axis_tdata[67:60]);
                compare_field("status", want.status, m_axis_tdata[70:68]);
                compare_field("last", want.last, m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        cfg_min_len = bdop_pkg::MIN_LEN_RESET;
        clear_parser();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_min_length_reset();
        test_header_extremes();
        test_option_records();
        test_truncated_options();
        test_backpressure();
        wait_idle();
        repeat (END_CYCLES) @(posedge i_clk);
        $display("Sent %0d packets in %0d byte transactions; checked %0d result transactions.",
                 packets_sent, bytes_sent, results_seen);
        $display("Covered header fields, option records, nested sub-options, status order, %s",
                 "the length register, four flow-control mixes and a long output stall.");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
